// ===== hdl/rc4_pkg.sv =====
// Shared constants and types for the RC4 stream cipher core.
package rc4_pkg;

	localparam int SBOX_SIZE      = 256;
	localparam int SBOX_AW        = $clog2(SBOX_SIZE);
	localparam int MAX_KEY_BYTES  = 16;
	localparam int KIDX_W         = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KEY_LEN_W      = 5;
	localparam int KEY_WORD_W     = 64;
	localparam int APB_DATA_W     = 64;
	localparam int APB_ADDR_W     = 5;

	localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = KEY_LEN_W'(16);

	// Register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_KEY_LENGTH     = 2'd0;
	localparam logic [1:0] REG_KEY_BYTES_LOW  = 2'd1;
	localparam logic [1:0] REG_KEY_BYTES_HIGH = 2'd2;

	typedef struct packed {
		logic [KEY_LEN_W-1:0]  key_length;
		logic [KEY_WORD_W-1:0] key_bytes_low;
		logic [KEY_WORD_W-1:0] key_bytes_high;
	} cfg_t;

endpackage

// ===== hdl/rc4_if.sv =====
// Valid/ready channel interfaces for cipher input and result bytes.
interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_message;

	modport source (output valid, output data_byte, output start_message, input ready);
	modport sink (input valid, input data_byte, input start_message, output ready);
endinterface

interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface

// ===== hdl/rc4_cfg.sv =====
// APB configuration registers holding the key and key length.
module rc4_cfg
	import rc4_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [KEY_LEN_W-1:0]  key_length_q;
	logic [KEY_WORD_W-1:0] key_bytes_low_q;
	logic [KEY_WORD_W-1:0] key_bytes_high_q;
	logic [1:0]            reg_sel;
	logic                  wr_en;

	assign reg_sel = paddr[4:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q     <= KEY_LENGTH_RESET;
			key_bytes_low_q  <= '0;
			key_bytes_high_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_KEY_LENGTH:     key_length_q     <= pwdata[KEY_LEN_W-1:0];
				REG_KEY_BYTES_LOW:  key_bytes_low_q  <= pwdata;
				REG_KEY_BYTES_HIGH: key_bytes_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_KEY_LENGTH:     prdata = {{(APB_DATA_W-KEY_LEN_W){1'b0}}, key_length_q};
			REG_KEY_BYTES_LOW:  prdata = key_bytes_low_q;
			REG_KEY_BYTES_HIGH: prdata = key_bytes_high_q;
			default:            prdata = '0;
		endcase
	end

	assign cfg.key_length     = key_length_q;
	assign cfg.key_bytes_low  = key_bytes_low_q;
	assign cfg.key_bytes_high = key_bytes_high_q;

endmodule

// ===== hdl/rc4_engine.sv =====
// Sequencer, state table memory and shared byte adder for key schedule and keystream.
module rc4_engine
	import rc4_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	rc4_in_if.sink           data_ch,
	rc4_out_if.source        result_ch
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FILL = 4'd1;
	localparam logic [3:0] ST_SA   = 4'd2;
	localparam logic [3:0] ST_SB   = 4'd3;
	localparam logic [3:0] ST_SC   = 4'd4;
	localparam logic [3:0] ST_SD   = 4'd5;
	localparam logic [3:0] ST_KA   = 4'd6;
	localparam logic [3:0] ST_KB   = 4'd7;
	localparam logic [3:0] ST_KC   = 4'd8;
	localparam logic [3:0] ST_KD   = 4'd9;

	localparam logic [SBOX_AW-1:0] LAST_IDX = SBOX_AW'(SBOX_SIZE - 1);

	logic [7:0]         sbox_mem [SBOX_SIZE];
	logic [7:0]         rd_q;
	logic               rd_en;
	logic [SBOX_AW-1:0] rd_addr;
	logic               wr_en;
	logic [SBOX_AW-1:0] wr_addr;
	logic [7:0]         wr_data;

	logic [3:0]         state_q;
	logic [SBOX_AW-1:0] n_q;
	logic [KIDX_W-1:0]  kidx_q;
	logic [7:0]         jk_q;
	logic [7:0]         sn_q;
	logic               fwd_q;
	logic [7:0]         idx_i_q;
	logic [7:0]         idx_j_q;
	logic [7:0]         si_q;
	logic [7:0]         sj_q;
	logic [7:0]         t_q;
	logic [7:0]         data_q;
	logic               sched_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;

	logic [KEY_LEN_W-1:0]      len_eff;
	logic [2*KEY_WORD_W-1:0]   key_word;
	logic [7:0]                key_byte;
	logic [7:0]                sn_cur;
	logic [7:0]                add_a;
	logic [7:0]                add_b;
	logic [7:0]                add_c;
	logic [7:0]                add_sum;
	logic [7:0]                i_next;
	logic [7:0]                st;
	logic                      out_free;
	logic                      in_xfer;
	logic                      kidx_wrap;

	// Clamp key length into 1..MAX_KEY_BYTES
	always_comb begin
		if (cfg.key_length == '0)
			len_eff = KEY_LEN_W'(1);
		else if (cfg.key_length > KEY_LEN_W'(MAX_KEY_BYTES))
			len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
		else
			len_eff = cfg.key_length;
	end

	assign key_word  = {cfg.key_bytes_high, cfg.key_bytes_low};
	assign key_byte  = key_word[{kidx_q, 3'b000} +: 8];
	assign kidx_wrap = (KEY_LEN_W'(kidx_q) + KEY_LEN_W'(1)) == len_eff;
	assign sn_cur    = fwd_q ? sn_q : rd_q;
	assign i_next    = idx_i_q + 8'd1;

	// Shared byte adder: schedule j, keystream j and keystream t
	always_comb begin
		case (state_q)
			ST_SB: begin
				add_a = jk_q;
				add_b = sn_cur;
				add_c = key_byte;
			end
			ST_KB: begin
				add_a = idx_j_q;
				add_b = rd_q;
				add_c = 8'd0;
			end
			default: begin
				add_a = si_q;
				add_b = rd_q;
				add_c = 8'd0;
			end
		endcase
		add_sum = add_a + add_b + add_c;
	end

	// Swap writes are not seen by the t read: correct the stale value
	always_comb begin
		if (t_q == idx_j_q)
			st = si_q;
		else if (t_q == idx_i_q)
			st = sj_q;
		else
			st = rd_q;
	end

	assign out_free = !out_valid_q || result_ch.ready;
	assign data_ch.ready = (state_q == ST_IDLE);
	assign in_xfer = data_ch.valid && (state_q == ST_IDLE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_next;
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = n_q;
		case (state_q)
			ST_IDLE: begin
				rd_en   = 1'b1;
				rd_addr = i_next;
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = n_q;
			end
			ST_SA: begin
				rd_en   = 1'b1;
				rd_addr = n_q;
			end
			ST_SB: begin
				rd_en   = 1'b1;
				rd_addr = add_sum;
			end
			ST_SC: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = rd_q;
			end
			ST_SD: begin
				wr_en   = 1'b1;
				wr_addr = jk_q;
				wr_data = sn_q;
				rd_en   = 1'b1;
				rd_addr = n_q + SBOX_AW'(1);
			end
			ST_KA: begin
				rd_en   = 1'b1;
				rd_addr = i_next;
			end
			ST_KB: begin
				rd_en   = 1'b1;
				rd_addr = add_sum;
			end
			ST_KC: begin
				wr_en   = 1'b1;
				wr_addr = idx_i_q;
				wr_data = rd_q;
				rd_en   = 1'b1;
				rd_addr = add_sum;
			end
			ST_KD: begin
				wr_en   = 1'b1;
				wr_addr = idx_j_q;
				wr_data = si_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			sbox_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= sbox_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			kidx_q      <= '0;
			jk_q        <= '0;
			fwd_q       <= 1'b0;
			idx_i_q     <= '0;
			idx_j_q     <= '0;
			sched_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_KD && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && result_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (data_ch.start_message || !sched_q) begin
							n_q     <= '0;
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_KB;
						end
					end
				end
				ST_FILL: begin
					n_q <= n_q + SBOX_AW'(1);
					if (n_q == LAST_IDX) begin
						jk_q    <= '0;
						kidx_q  <= '0;
						fwd_q   <= 1'b0;
						state_q <= ST_SA;
					end
				end
				ST_SA: state_q <= ST_SB;
				ST_SB: begin
					jk_q    <= add_sum;
					kidx_q  <= kidx_wrap ? '0 : kidx_q + KIDX_W'(1);
					state_q <= ST_SC;
				end
				ST_SC: state_q <= ST_SD;
				ST_SD: begin
					if (n_q == LAST_IDX) begin
						idx_i_q <= '0;
						idx_j_q <= '0;
						sched_q <= 1'b1;
						state_q <= ST_KA;
					end else begin
						n_q     <= n_q + SBOX_AW'(1);
						fwd_q   <= (n_q + SBOX_AW'(1)) == jk_q;
						state_q <= ST_SB;
					end
				end
				ST_KA: state_q <= ST_KB;
				ST_KB: begin
					idx_i_q <= i_next;
					idx_j_q <= add_sum;
					state_q <= ST_KC;
				end
				ST_KC: state_q <= ST_KD;
				ST_KD: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			data_q <= data_ch.data_byte;
		if (state_q == ST_SB)
			sn_q <= sn_cur;
		if (state_q == ST_KB)
			si_q <= rd_q;
		if (state_q == ST_KC) begin
			sj_q <= rd_q;
			t_q  <= add_sum;
		end
		if (state_q == ST_KD && out_free)
			out_byte_q <= data_q ^ st;
	end

	assign result_ch.valid    = out_valid_q;
	assign result_ch.out_byte = out_byte_q;

endmodule

// ===== hdl/rc4_stream_cipher_core.sv =====
// RC4 stream cipher core: one output byte per input byte.
// Input channel data_ch carries data_byte and start_message; a transfer
// happens when valid and ready are both high. Output channel result_ch
// carries out_byte = data_byte XOR keystream byte, one per input.
// Key and key length sit in APB registers at byte addresses 0, 8 and 16;
// write them only while the core is idle.
// ready is high only while the sequencer is idle. An ordinary byte's result
// is registered as the sequencer leaves state KD, after states KB and KC, and
// the next transfer can follow once it is back in idle, so no new byte is taken
// before the last is done. Table reads and swap writes go through one table and one shared adder.
// A byte marked start_message, or the first byte after reset, first runs
// the key schedule: a fill pass over all 256 entries, then one key-driven
// swap per entry through states SB, SC and SD, before its result.
// Reset clears the indices and forces a key schedule on the next byte; the
// key registers return to length 16 and all-zero key bytes.
// While the receiver stalls, the finished byte holds in the output register
// and the core still takes one more input, then waits for the register to drain.
module rc4_stream_cipher_core
	import rc4_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rc4_in_if.sink                data_ch,
	rc4_out_if.source             result_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t cfg;

	rc4_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rc4_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.data_ch   (data_ch),
		.result_ch (result_ch)
	);

endmodule
